@@ rtl/lobatto_poly_value_derivative_assert.svh @@
// Assertion macros for the Lobatto evaluator checker.
`ifndef LOBATTO_POLY_VALUE_DERIVATIVE_ASSERT_SVH
`define LOBATTO_POLY_VALUE_DERIVATIVE_ASSERT_SVH

// same-cycle implication
`define LPVD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpvd assertion failed");

// next-cycle implication
`define LPVD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpvd assertion failed");

`endif

@@ rtl/lpvd_pkg.sv @@
package lpvd_pkg;

  localparam int DEF_MAX_ORDER = 32;
  localparam int CFG_W         = 6;
  localparam logic [CFG_W-1:0] TOP_RESET = 6'd10;
  localparam int PT_W          = 32;
  localparam int VAL_W         = 48;
  localparam int FRAC_W        = 30;
  localparam int OPA_W         = 32;
  localparam int CHUNK_W       = 25;
  localparam int OPB_W         = 2 * CHUNK_W;
  localparam int ACC_W         = OPA_W + OPB_W + 2;

  localparam logic signed [VAL_W-1:0] SAT_HI = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] SAT_LO = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] Q_ONE  = VAL_W'(1) << FRAC_W;

  typedef struct packed {
    logic signed [PT_W-1:0] point;
    logic                   last_point;
  } in_word_t;

  typedef struct packed {
    logic [CFG_W-1:0]        order;
    logic signed [VAL_W-1:0] poly_value;
    logic signed [VAL_W-1:0] poly_slope;
    logic                    last_order;
    logic                    batch_done;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_FINISH,
    ST_EMIT,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_DIV_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_XC,
    OP_XS,
    OP_VAL,
    OP_SLO,
    OP_NP1,
    OP_NP2,
    OP_NS1,
    OP_NS2
  } op_e;

  // sign-magnitude to saturated 48-bit signed
  function automatic logic signed [VAL_W-1:0] sat_mag(input logic [ACC_W-1:0] m,
                                                       input logic neg);
    logic [ACC_W-1:0] lim;
    logic signed [VAL_W-1:0] r;
    lim = ACC_W'(1) << (VAL_W - 1);
    if (neg) begin
      if (m >= lim) r = SAT_LO;
      else r = -$signed(m[VAL_W-1:0]);
    end else begin
      if (m >= lim) r = SAT_HI;
      else r = $signed(m[VAL_W-1:0]);
    end
    return r;
  endfunction

endpackage

@@ rtl/lobatto_poly_value_derivative.sv @@
// Completed Lobatto polynomial evaluator. For each point word x (signed Q2.30)
// the block emits one result word per order k = 1 .. top_order with
// L(k,x) = k*(P(k-1)-x*P(k)) and L'(k,x) = k*(P'(k-1)-P(k)-x*P'(k)) in signed
// Q18.30, saturated, with last_order on the top order and batch_done when that
// word also ends a batch. top_order is written through cfg_we_i/cfg_wdata_i;
// the user must write it only while the block is idle, as the block itself
// does not enforce this. It is clamped to 1 .. MAX_ORDER. All arithmetic runs
// on one 32x25 multiply-accumulate unit and one radix-2 divider under a small
// sequencer; the block takes no new point until the last order has been
// handed to the output register. Each step from one order to the next runs
// two divisions, one quotient bit per cycle, on a dividend of
// DW = 49 + clog2(2*MAX_ORDER) bits (55 at MAX_ORDER 32).
module lobatto_poly_value_derivative #(
  parameter int MAX_ORDER = lpvd_pkg::DEF_MAX_ORDER
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  lpvd_pkg::in_word_t           in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output lpvd_pkg::out_word_t          out_word_o,
  input  logic                         cfg_we_i,
  input  logic [lpvd_pkg::CFG_W-1:0]   cfg_wdata_i
);

  localparam int KW    = $clog2(MAX_ORDER + 1);
  localparam int CW    = $clog2(2 * MAX_ORDER);
  localparam int DW    = 49 + CW;
  localparam int DCW   = $clog2(DW);
  localparam int VAL_W = lpvd_pkg::VAL_W;
  localparam int OPA_W = lpvd_pkg::OPA_W;
  localparam int OPB_W = lpvd_pkg::OPB_W;
  localparam int CHW   = lpvd_pkg::CHUNK_W;
  localparam int ACC_W = lpvd_pkg::ACC_W;
  localparam int PT_W  = lpvd_pkg::PT_W;

  lpvd_pkg::state_e state_q, state_d;
  lpvd_pkg::op_e    op_q, op_d;

  logic [lpvd_pkg::CFG_W-1:0] cfg_top_q;
  logic [KW-1:0]              top_q, top_d, k_q, k_d;
  logic                       last_q, last_d;
  logic signed [PT_W-1:0]     x_q, x_d;
  logic signed [VAL_W-1:0]    lp_q, lp_d, lc_q, lc_d, sp_q, sp_d, sc_q, sc_d;
  logic signed [VAL_W-1:0]    xc_q, xc_d, xs_q, xs_d, val_q, val_d, slo_q, slo_d;
  logic signed [VAL_W-1:0]    np_q, np_d;
  logic [OPA_W-1:0]           a_q, a_d;
  logic [OPB_W-1:0]           b_q, b_d;
  logic                       mac_neg_q, mac_neg_d, res_neg_q, res_neg_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic [DW-1:0]              dv_q, dv_d;
  logic [KW-1:0]              rem_q, rem_d;
  logic [DCW-1:0]             cnt_q, cnt_d;
  logic                       div_neg_q, div_neg_d;
  logic                       out_valid_q, out_valid_d;
  lpvd_pkg::out_word_t        out_q, out_d;

  logic                       take, out_free, fin, single_op, b_neg, acc_neg, q_bit;
  logic [6:0]                 top_ext;
  logic [KW-1:0]              top_eff, d_val;
  logic [OPA_W-1:0]           x_mag, a_pick;
  logic signed [OPB_W-1:0]    b_pick, diff_v, diff_s;
  logic signed [VAL_W:0]      sm_sum;
  logic signed [VAL_W-1:0]    sm_sat;
  logic [OPB_W-1:0]           b_mag;
  logic [CHW-1:0]             chunk;
  logic [OPA_W+CHW-1:0]       prod;
  logic [ACC_W-1:0]           term, acc_mag, rnd;
  logic [KW:0]                rem_sh;

  assign take     = in_valid_i && (state_q == lpvd_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign fin      = (k_q == top_q);

  always_comb begin
    top_ext = {1'b0, cfg_top_q};
    if (top_ext == 7'd0) top_ext = 7'd1;
    if (top_ext > 7'(MAX_ORDER)) top_ext = 7'(MAX_ORDER);
    top_eff = KW'(top_ext);
  end

  // next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      lpvd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = lpvd_pkg::ST_LOAD;
          op_d    = lpvd_pkg::OP_XC;
        end
      end
      lpvd_pkg::ST_LOAD: state_d = lpvd_pkg::ST_MUL_LO;
      lpvd_pkg::ST_MUL_LO: state_d = lpvd_pkg::ST_MUL_HI;
      lpvd_pkg::ST_MUL_HI: begin
        case (op_q) inside
          lpvd_pkg::OP_NP1: begin
            state_d = lpvd_pkg::ST_LOAD;
            op_d    = lpvd_pkg::OP_NP2;
          end
          lpvd_pkg::OP_NS1: begin
            state_d = lpvd_pkg::ST_LOAD;
            op_d    = lpvd_pkg::OP_NS2;
          end
          lpvd_pkg::OP_NP2, lpvd_pkg::OP_NS2: state_d = lpvd_pkg::ST_DIV_INIT;
          default: state_d = lpvd_pkg::ST_FINISH;
        endcase
      end
      lpvd_pkg::ST_FINISH: begin
        case (op_q)
          lpvd_pkg::OP_XC: begin
            state_d = lpvd_pkg::ST_LOAD;
            op_d    = lpvd_pkg::OP_XS;
          end
          lpvd_pkg::OP_XS: begin
            state_d = lpvd_pkg::ST_LOAD;
            op_d    = lpvd_pkg::OP_VAL;
          end
          lpvd_pkg::OP_VAL: begin
            state_d = lpvd_pkg::ST_LOAD;
            op_d    = lpvd_pkg::OP_SLO;
          end
          default: state_d = lpvd_pkg::ST_EMIT;
        endcase
      end
      lpvd_pkg::ST_EMIT: begin
        if (out_free) begin
          if (fin) begin
            state_d = lpvd_pkg::ST_IDLE;
          end else begin
            state_d = lpvd_pkg::ST_LOAD;
            op_d    = lpvd_pkg::OP_NP1;
          end
        end
      end
      lpvd_pkg::ST_DIV_INIT: state_d = lpvd_pkg::ST_DIV_RUN;
      lpvd_pkg::ST_DIV_RUN: begin
        if (cnt_q == '0) state_d = lpvd_pkg::ST_DIV_DONE;
      end
      lpvd_pkg::ST_DIV_DONE: begin
        state_d = lpvd_pkg::ST_LOAD;
        op_d    = (op_q == lpvd_pkg::OP_NP2) ? lpvd_pkg::OP_NS1 : lpvd_pkg::OP_XC;
      end
      default: state_d = lpvd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o  = (state_q != lpvd_pkg::ST_IDLE);
    out_valid_o = out_valid_q;
    out_word_o  = out_q;
  end

  // operand select for the shared MAC
  always_comb begin
    x_mag  = OPA_W'(x_q[PT_W-1] ? -x_q : x_q);
    diff_v = OPB_W'(lp_q) - OPB_W'(xc_q);
    diff_s = OPB_W'(sp_q) - OPB_W'(lc_q) - OPB_W'(xs_q);
    sm_sum = {lc_q[VAL_W-1], lc_q} + {xs_q[VAL_W-1], xs_q};
    if (sm_sum[VAL_W] != sm_sum[VAL_W-1]) begin
      sm_sat = sm_sum[VAL_W] ? lpvd_pkg::SAT_LO : lpvd_pkg::SAT_HI;
    end else begin
      sm_sat = sm_sum[VAL_W-1:0];
    end
    a_pick = OPA_W'(k_q);
    b_pick = OPB_W'(lc_q);
    case (op_q)
      lpvd_pkg::OP_XC: begin
        a_pick = x_mag;
        b_pick = OPB_W'(lc_q);
      end
      lpvd_pkg::OP_XS: begin
        a_pick = x_mag;
        b_pick = OPB_W'(sc_q);
      end
      lpvd_pkg::OP_VAL: b_pick = diff_v;
      lpvd_pkg::OP_SLO: b_pick = diff_s;
      lpvd_pkg::OP_NP1: begin
        a_pick = OPA_W'({k_q, 1'b1});
        b_pick = OPB_W'(xc_q);
      end
      lpvd_pkg::OP_NP2: b_pick = -OPB_W'(lp_q);
      lpvd_pkg::OP_NS1: begin
        a_pick = OPA_W'({k_q, 1'b1});
        b_pick = OPB_W'(sm_sat);
      end
      lpvd_pkg::OP_NS2: b_pick = -OPB_W'(sp_q);
      default: ;
    endcase
    b_neg     = b_pick[OPB_W-1];
    b_mag     = b_neg ? OPB_W'(-b_pick) : OPB_W'(b_pick);
    single_op = (op_q == lpvd_pkg::OP_XC) || (op_q == lpvd_pkg::OP_XS) ||
                (op_q == lpvd_pkg::OP_VAL) || (op_q == lpvd_pkg::OP_SLO);
  end

  // shared multiplier, divider step
  always_comb begin
    chunk   = (state_q == lpvd_pkg::ST_MUL_HI) ? b_q[OPB_W-1:CHW] : b_q[CHW-1:0];
    prod    = a_q * chunk;
    term    = (state_q == lpvd_pkg::ST_MUL_HI) ? (ACC_W'(prod) << CHW) : ACC_W'(prod);
    acc_neg = acc_q[ACC_W-1];
    acc_mag = acc_neg ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    rnd     = (ACC_W'(acc_q) + (ACC_W'(1) << (lpvd_pkg::FRAC_W - 1))) >> lpvd_pkg::FRAC_W;
    d_val   = k_q + KW'(1);
    rem_sh  = {rem_q, dv_q[DW-1]};
    q_bit   = (rem_sh >= {1'b0, d_val});
  end

  // datapath
  always_comb begin
    top_d       = top_q;
    k_d         = k_q;
    last_d      = last_q;
    x_d         = x_q;
    lp_d        = lp_q;
    lc_d        = lc_q;
    sp_d        = sp_q;
    sc_d        = sc_q;
    xc_d        = xc_q;
    xs_d        = xs_q;
    val_d       = val_q;
    slo_d       = slo_q;
    np_d        = np_q;
    a_d         = a_q;
    b_d         = b_q;
    mac_neg_d   = mac_neg_q;
    res_neg_d   = res_neg_q;
    acc_d       = acc_q;
    dv_d        = dv_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    div_neg_d   = div_neg_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      lpvd_pkg::ST_IDLE: begin
        if (take) begin
          x_d    = in_word_i.point;
          last_d = in_word_i.last_point;
          top_d  = top_eff;
          k_d    = KW'(1);
          lp_d   = lpvd_pkg::Q_ONE;
          lc_d   = VAL_W'(in_word_i.point);
          sp_d   = '0;
          sc_d   = lpvd_pkg::Q_ONE;
        end
      end
      lpvd_pkg::ST_LOAD: begin
        a_d = a_pick;
        b_d = b_mag;
        if (single_op) begin
          mac_neg_d = 1'b0;
          res_neg_d = b_neg ^ (((op_q == lpvd_pkg::OP_XC) || (op_q == lpvd_pkg::OP_XS)) &&
                               x_q[PT_W-1]);
        end else begin
          mac_neg_d = b_neg;
        end
        if ((op_q != lpvd_pkg::OP_NP2) && (op_q != lpvd_pkg::OP_NS2)) acc_d = '0;
      end
      lpvd_pkg::ST_MUL_LO, lpvd_pkg::ST_MUL_HI: begin
        acc_d = mac_neg_q ? (acc_q - $signed(term)) : (acc_q + $signed(term));
      end
      lpvd_pkg::ST_FINISH: begin
        case (op_q)
          lpvd_pkg::OP_XC: xc_d = lpvd_pkg::sat_mag(rnd, res_neg_q);
          lpvd_pkg::OP_XS: xs_d = lpvd_pkg::sat_mag(rnd, res_neg_q);
          lpvd_pkg::OP_VAL: val_d = lpvd_pkg::sat_mag(ACC_W'(acc_q), res_neg_q);
          lpvd_pkg::OP_SLO: slo_d = lpvd_pkg::sat_mag(ACC_W'(acc_q), res_neg_q);
          default: ;
        endcase
      end
      lpvd_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.order      = lpvd_pkg::CFG_W'(k_q);
          out_d.poly_value = val_q;
          out_d.poly_slope = slo_q;
          out_d.last_order = fin;
          out_d.batch_done = fin && last_q;
        end
      end
      lpvd_pkg::ST_DIV_INIT: begin
        // rounded quotient: (|num| + d/2) / d
        dv_d      = DW'(acc_mag + ACC_W'(d_val >> 1));
        rem_d     = '0;
        cnt_d     = DCW'(DW - 1);
        div_neg_d = acc_neg;
      end
      lpvd_pkg::ST_DIV_RUN: begin
        rem_d = q_bit ? KW'(rem_sh - {1'b0, d_val}) : rem_sh[KW-1:0];
        dv_d  = {dv_q[DW-2:0], q_bit};
        cnt_d = cnt_q - DCW'(1);
      end
      lpvd_pkg::ST_DIV_DONE: begin
        if (op_q == lpvd_pkg::OP_NP2) begin
          np_d = lpvd_pkg::sat_mag(ACC_W'(dv_q), div_neg_q);
        end else begin
          lp_d = lc_q;
          lc_d = np_q;
          sp_d = sc_q;
          sc_d = lpvd_pkg::sat_mag(ACC_W'(dv_q), div_neg_q);
          k_d  = k_q + KW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpvd_pkg::ST_IDLE;
      op_q        <= lpvd_pkg::OP_XC;
      cfg_top_q   <= lpvd_pkg::TOP_RESET;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) cfg_top_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q     <= top_d;
    last_q    <= last_d;
    x_q       <= x_d;
    lp_q      <= lp_d;
    lc_q      <= lc_d;
    sp_q      <= sp_d;
    sc_q      <= sc_d;
    xc_q      <= xc_d;
    xs_q      <= xs_d;
    val_q     <= val_d;
    slo_q     <= slo_d;
    np_q      <= np_d;
    a_q       <= a_d;
    b_q       <= b_d;
    mac_neg_q <= mac_neg_d;
    res_neg_q <= res_neg_d;
    acc_q     <= acc_d;
    dv_q      <= dv_d;
    rem_q     <= rem_d;
    div_neg_q <= div_neg_d;
    out_q     <= out_d;
  end

endmodule

@@ rtl/lpvd_check.sv @@
`include "lobatto_poly_value_derivative_assert.svh"

module lpvd_check (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input lpvd_pkg::in_word_t           in_word_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input lpvd_pkg::out_word_t          out_word_o,
  input logic                         cfg_we_i,
  input logic [lpvd_pkg::CFG_W-1:0]   cfg_wdata_i
);

  // a taken point keeps the block busy
  `LPVD_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // a word that is not the top order leaves work pending
  `LPVD_ASSERT_NOW(a_busy_mid_point, clk_i, rst_ni, out_valid_o && !out_stall_i && !out_word_o.last_order, in_stall_o)

  // stalled result word holds
  `LPVD_ASSERT_NXT(a_hold_word, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o))

endmodule

bind lobatto_poly_value_derivative lpvd_check u_lpvd_check (.*);
